>>> rtl/core/avt_pkg.sv
// Shared constants, configuration and pipeline bundle types for the affine vertex transform.
package avt_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int FIELD_W     = 32;
    localparam int ELEM_W      = 32;
    localparam int NUM_ROWS    = 3;
    localparam int NUM_COLS    = 4;
    localparam int NUM_TERMS   = 3;
    localparam int PROD_W      = ELEM_W + COORD_WIDTH;
    localparam int ACC_W       = PROD_W + 3;
    localparam int SH_W        = ACC_W - FRAC_BITS;
    localparam int TDATA_W     = NUM_TERMS * FIELD_W;
    localparam int REG_W       = 64;
    localparam int NUM_ROW_REGS = 2 * NUM_ROWS;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = IDX_W + 3;

    localparam logic [IDX_W-1:0] REG_DIM_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS01 = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW0_COLS23 = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS01 = 3'd3;
    localparam logic [IDX_W-1:0] REG_ROW1_COLS23 = 3'd4;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS01 = 3'd5;
    localparam logic [IDX_W-1:0] REG_ROW2_COLS23 = 3'd6;

    localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0]  DIAG_LO  = {{(REG_W-ELEM_W){1'b0}}, ELEM_ONE};
    localparam logic [REG_W-1:0]  DIAG_HI  = {ELEM_ONE, {(REG_W-ELEM_W){1'b0}}};

    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_BITS - 1);

    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [FIELD_W-1:0] OUT_MAX = FIELD_W'($signed(COORD_MAX));
    localparam logic [FIELD_W-1:0] OUT_MIN = FIELD_W'($signed(COORD_MIN));

    typedef struct packed {
        logic                                          dim_mode;
        logic [NUM_ROWS-1:0][NUM_COLS-1:0][ELEM_W-1:0] m;
    } avt_cfg_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0][NUM_TERMS-1:0][PROD_W-1:0] p;
        logic                                           last;
    } avt_prod_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0][ACC_W-1:0] pa;
        logic [NUM_ROWS-1:0][ACC_W-1:0] pb;
        logic                           last;
    } avt_part_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0][ACC_W-1:0] acc;
        logic                           last;
    } avt_acc_t;

endpackage

>>> rtl/core/avt_regs.sv
// Configuration register file with APB-style access: mode bit and the 3x4 matrix.
module avt_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [avt_pkg::ADDR_W-1:0]  paddr,
    input  logic [avt_pkg::REG_W-1:0]   pwdata,
    output logic [avt_pkg::REG_W-1:0]   prdata,
    output logic                        pready,
    output avt_pkg::avt_cfg_t           cfg
);
    import avt_pkg::*;

    logic                   dim_mode_reg;
    logic [REG_W-1:0]       rows_reg [NUM_ROW_REGS];
    logic [IDX_W-1:0]       idx;
    logic [IDX_W-1:0]       row_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign idx     = paddr[ADDR_W-1:3];
    assign row_idx = idx - IDX_W'(1);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_mode_reg <= 1'b0;
            rows_reg[0]  <= DIAG_LO;
            rows_reg[1]  <= '0;
            rows_reg[2]  <= DIAG_HI;
            rows_reg[3]  <= '0;
            rows_reg[4]  <= '0;
            rows_reg[5]  <= DIAG_LO;
        end else if (wr_en) begin
            case (idx)
                REG_DIM_MODE: begin
                    dim_mode_reg <= pwdata[0];
                end
                REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01,
                REG_ROW1_COLS23, REG_ROW2_COLS01, REG_ROW2_COLS23: begin
                    rows_reg[row_idx] <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_DIM_MODE: begin
                prdata = {{(REG_W-1){1'b0}}, dim_mode_reg};
            end
            REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01,
            REG_ROW1_COLS23, REG_ROW2_COLS01, REG_ROW2_COLS23: begin
                prdata = rows_reg[row_idx];
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_comb begin
        cfg.dim_mode = dim_mode_reg;
        for (int r = 0; r < NUM_ROWS; r++) begin
            cfg.m[r][0] = rows_reg[2*r][ELEM_W-1:0];
            cfg.m[r][1] = rows_reg[2*r][REG_W-1:ELEM_W];
            cfg.m[r][2] = rows_reg[2*r+1][ELEM_W-1:0];
            cfg.m[r][3] = rows_reg[2*r+1][REG_W-1:ELEM_W];
        end
    end

endmodule

>>> rtl/core/avt_mul.sv
// Multiplier stage: nine signed element-by-coordinate products, registered.
module avt_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  avt_pkg::avt_cfg_t                  cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [avt_pkg::COORD_WIDTH-1:0]    in_x,
    input  logic [avt_pkg::COORD_WIDTH-1:0]    in_y,
    input  logic [avt_pkg::COORD_WIDTH-1:0]    in_z,
    input  logic                               in_last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output avt_pkg::avt_prod_t                 out_data
);
    import avt_pkg::*;

    logic                          valid_reg;
    avt_prod_t                     data_reg;
    avt_prod_t                     data_next;
    logic signed [COORD_WIDTH-1:0] vec [NUM_TERMS];
    logic signed [PROD_W-1:0]      prod;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        vec[0] = $signed(in_x);
        vec[1] = $signed(in_y);
        vec[2] = cfg.dim_mode ? '0 : $signed(in_z);
        data_next.last = in_last;
        prod = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            for (int c = 0; c < NUM_TERMS; c++) begin
                prod = $signed(cfg.m[r][c]) * vec[c];
                data_next.p[r][c] = prod;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> rtl/core/avt_sum.sv
// Two adder stages: partial sums with translation and rounding bias, then the row totals.
module avt_sum (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  avt_pkg::avt_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  avt_pkg::avt_prod_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output avt_pkg::avt_acc_t    out_data
);
    import avt_pkg::*;

    logic      part_valid_reg;
    avt_part_t part_reg;
    avt_part_t part_next;
    logic      part_ready;
    logic      acc_valid_reg;
    avt_acc_t  acc_reg;
    avt_acc_t  acc_next;

    assign part_ready = !acc_valid_reg || out_ready;
    assign in_ready   = !part_valid_reg || part_ready;
    assign out_valid  = acc_valid_reg;
    assign out_data   = acc_reg;

    always_comb begin
        part_next.last = in_data.last;
        for (int r = 0; r < NUM_ROWS; r++) begin
            part_next.pa[r] = ACC_W'($signed(in_data.p[r][0]))
                            + ACC_W'($signed(in_data.p[r][1]));
            part_next.pb[r] = ACC_W'($signed(in_data.p[r][2]))
                            + (ACC_W'($signed(cfg.m[r][3])) <<< FRAC_BITS)
                            + ROUND_BIAS;
        end
    end

    always_comb begin
        acc_next.last = part_reg.last;
        for (int r = 0; r < NUM_ROWS; r++) begin
            acc_next.acc[r] = part_reg.pa[r] + part_reg.pb[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            part_valid_reg <= 1'b0;
            acc_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                part_valid_reg <= in_valid;
            end
            if (part_ready) begin
                acc_valid_reg <= part_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            part_reg <= part_next;
        end
        if (part_ready && part_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

endmodule

>>> rtl/core/avt_sat.sv
// Output stage: drop fraction bits, saturate each coordinate and hold the result transfer.
module avt_sat (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  avt_pkg::avt_cfg_t                 cfg,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  avt_pkg::avt_acc_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [avt_pkg::TDATA_W-1:0]       out_coords,
    output logic                              out_overflow,
    output logic                              out_last
);
    import avt_pkg::*;

    logic                   valid_reg;
    logic [TDATA_W-1:0]     coords_reg;
    logic                   ovf_reg;
    logic                   last_reg;
    logic [TDATA_W-1:0]     coords_next;
    logic                   ovf_next;
    logic [SH_W-1:0]        shifted;
    logic [SH_W-COORD_WIDTH:0] top;
    logic                   row_ovf;
    logic [COORD_WIDTH-1:0] res;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_coords   = coords_reg;
    assign out_overflow = ovf_reg;
    assign out_last     = last_reg;

    always_comb begin
        ovf_next    = 1'b0;
        coords_next = '0;
        shifted     = '0;
        top         = '0;
        row_ovf     = 1'b0;
        res         = '0;
        for (int r = 0; r < NUM_ROWS; r++) begin
            shifted = in_data.acc[r][ACC_W-1:FRAC_BITS];
            top     = shifted[SH_W-1:COORD_WIDTH-1];
            row_ovf = !((&top) || !(|top));
            if (row_ovf) begin
                res = shifted[SH_W-1] ? COORD_MIN : COORD_MAX;
            end else begin
                res = shifted[COORD_WIDTH-1:0];
            end
            if (r == NUM_ROWS - 1 && cfg.dim_mode) begin
                res     = '0;
                row_ovf = 1'b0;
            end
            ovf_next = ovf_next | row_ovf;
            coords_next[r*FIELD_W +: FIELD_W] = FIELD_W'($signed(res));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            coords_reg <= coords_next;
            ovf_reg    <= ovf_next;
            last_reg   <= in_data.last;
        end
    end

endmodule

>>> rtl/core/affine_vertex_transform.sv
// Top level of the affine vertex transform: register file and four-stage arithmetic pipeline.
//
// Transforms one Q16.16 vertex per clock by a 3x4 affine matrix (w taken as 1), rounding
// each coordinate to nearest (ties upward) and saturating it to 32 bits; m_tuser flags any
// saturation and tlast passes through. In 2D mode z is ignored and out_z is zero. A transfer
// is accepted every cycle while the pipeline is not stalled; it passes through four register
// stages in order: products, partial sums with translation, row totals, round/saturate output
// register. Each stage moves when it is empty or its successor moves, so back-pressure
// stalls without loss. Matrix registers sit at byte address 8*i, reset to identity, and are
// read directly by the datapath, so write them only while no vertex is in flight.
module affine_vertex_transform (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [avt_pkg::TDATA_W-1:0] s_tdata,   // in_x, in_y, in_z
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [avt_pkg::TDATA_W-1:0] m_tdata,   // out_x, out_y, out_z
    output logic                        m_tuser,   // out_overflow
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [avt_pkg::ADDR_W-1:0]  paddr,
    input  logic [avt_pkg::REG_W-1:0]   pwdata,
    output logic [avt_pkg::REG_W-1:0]   prdata,
    output logic                        pready
);
    import avt_pkg::*;

    avt_cfg_t  cfg;
    logic      prod_valid;
    logic      prod_ready;
    avt_prod_t prod_data;
    logic      acc_valid;
    logic      acc_ready;
    avt_acc_t  acc_data;

    avt_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    avt_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_x      (s_tdata[COORD_WIDTH-1:0]),
        .in_y      (s_tdata[FIELD_W +: COORD_WIDTH]),
        .in_z      (s_tdata[2*FIELD_W +: COORD_WIDTH]),
        .in_last   (s_tlast),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    avt_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (acc_valid),
        .out_ready (acc_ready),
        .out_data  (acc_data)
    );

    avt_sat u_sat (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .in_valid     (acc_valid),
        .in_ready     (acc_ready),
        .in_data      (acc_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_coords   (m_tdata),
        .out_overflow (m_tuser),
        .out_last     (m_tlast)
    );

    a_z_zero_2d: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cfg.dim_mode |-> m_tdata[2*FIELD_W +: FIELD_W] == '0)
        else $error("out_z nonzero in 2D mode");

    a_ovf_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[FIELD_W-1:0] == OUT_MAX || m_tdata[FIELD_W-1:0] == OUT_MIN ||
            m_tdata[FIELD_W +: FIELD_W] == OUT_MAX || m_tdata[FIELD_W +: FIELD_W] == OUT_MIN ||
            m_tdata[2*FIELD_W +: FIELD_W] == OUT_MAX ||
            m_tdata[2*FIELD_W +: FIELD_W] == OUT_MIN)
        else $error("overflow flagged without a clamped coordinate");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for affine_vertex_transform: matrix/mode phases, random vertices.
`timescale 1ns / 100ps

module tb_top;
    import avt_pkg::*;

    localparam int HALF_PERIOD = 1;
    localparam int RESET_CYCLES = 2;
    localparam int IDLE_PCT = 38;
    localparam int SETTLE_CYCLES = 8;
    localparam int SINK_HOLD_CYCLES = 100;
    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 50;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } vertex_t;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        ovf;
        logic        last;
    } xform_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata = '0;
    logic                s_tlast = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [REG_W-1:0]    pwdata = '0;
    logic [REG_W-1:0]    prdata;
    logic                pready;

    vertex_t             pending_vertices[$];
    xform_t              expected_coords[$];
    vertex_t             drv_vertex;
    xform_t              exp_coord;
    logic                cfg_mode = 1'b0;
    logic [REG_W-1:0]    cfg_mat[NUM_ROW_REGS] = '{DIAG_LO, '0, DIAG_HI, '0, '0, DIAG_LO};
    logic                steady = 1'b0;
    logic                hold_trigger = 1'b0;
    logic                hold_done = 1'b0;
    int                  hold_cnt = 0;
    int                  mismatch_cnt = 0;
    int                  cycle_cnt = 0;

    affine_vertex_transform DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // one matrix row: {saturated flag, coordinate}
    function automatic logic [32:0] row_coord(input logic signed [31:0] a, b, c, t,
                                              input logic signed [31:0] x, y, z);
        logic signed [127:0] ea, eb, ec, et, ex, ey, ez, acc, q;
        ea = a; eb = b; ec = c; et = t;
        ex = x; ey = y; ez = z;
        acc = ea * ex + eb * ey + ec * ez + (et <<< FRAC_BITS) + (128'sd1 <<< (FRAC_BITS - 1));
        q = acc >>> FRAC_BITS;
        if (q > SAT_HI)
            return {1'b1, OUT_MAX};
        else if (q < SAT_LO)
            return {1'b1, OUT_MIN};
        return {1'b0, q[31:0]};
    endfunction

    function automatic xform_t transform_vertex(input logic [TDATA_W-1:0] data,
                                                input logic last);
        logic [31:0] x, y, z;
        logic [32:0] rx, ry, rz;
        xform_t r;
        x = data[31:0];
        y = data[63:32];
        z = data[95:64];
        if (cfg_mode) begin
            rx = row_coord(cfg_mat[0][31:0], cfg_mat[0][63:32], '0, cfg_mat[1][63:32],
                           x, y, '0);
            ry = row_coord(cfg_mat[2][31:0], cfg_mat[2][63:32], '0, cfg_mat[3][63:32],
                           x, y, '0);
            rz = '0;
        end else begin
            rx = row_coord(cfg_mat[0][31:0], cfg_mat[0][63:32], cfg_mat[1][31:0],
                           cfg_mat[1][63:32], x, y, z);
            ry = row_coord(cfg_mat[2][31:0], cfg_mat[2][63:32], cfg_mat[3][31:0],
                           cfg_mat[3][63:32], x, y, z);
            rz = row_coord(cfg_mat[4][31:0], cfg_mat[4][63:32], cfg_mat[5][31:0],
                           cfg_mat[5][63:32], x, y, z);
        end
        r.x = rx[31:0];
        r.y = ry[31:0];
        r.z = rz[31:0];
        r.ovf = rx[32] | ry[32] | rz[32];
        r.last = last;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(6))
            0: begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0;
                endcase
            end
            1, 2, 3: v = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
            4, 5: v = $urandom;
            default: v = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_elem();
        logic [31:0] v;
        case ($urandom_range(7))
            0: v = 32'h0;
            1: v = ELEM_ONE;
            2: v = -ELEM_ONE;
            3: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4, 5: v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_DIM_MODE)
            cfg_mode = val[0];
        else if (idx <= REG_ROW2_COLS23)
            cfg_mat[idx - IDX_W'(1)] = val;
    endtask

    task automatic load_config(input logic [REG_W-1:0] mode,
                               input logic [REG_W-1:0] r0, r1, r2, r3, r4, r5);
        write_reg(REG_DIM_MODE, mode);
        write_reg(REG_ROW0_COLS01, r0);
        write_reg(REG_ROW0_COLS23, r1);
        write_reg(REG_ROW1_COLS01, r2);
        write_reg(REG_ROW1_COLS23, r3);
        write_reg(REG_ROW2_COLS01, r4);
        write_reg(REG_ROW2_COLS23, r5);
    endtask

    task automatic wait_drained();
        while (pending_vertices.size() != 0 || s_tvalid || expected_coords.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_vertex(input logic [31:0] x, y, z, input logic last);
        vertex_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        v.last = last;
        pending_vertices.push_back(v);
    endtask

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++)
            push_vertex(rand_coord(), rand_coord(), rand_coord(), $urandom_range(7) == 0);
    endtask

    // source side: hold data until the transfer, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_coords.push_back(transform_vertex(s_tdata, s_tlast));
            if (!s_tvalid || s_tready) begin
                if (pending_vertices.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    drv_vertex = pending_vertices.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {drv_vertex.z, drv_vertex.y, drv_vertex.x};
                    s_tlast <= drv_vertex.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            hold_cnt <= SINK_HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // sink side: check each transfer against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_coords.size() == 0) begin
                    if (mismatch_cnt < MAX_REPORTS)
                        $display("unexpected transfer: x=%h y=%h z=%h ovf=%b last=%b",
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser, m_tlast);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    exp_coord = expected_coords.pop_front();
                    if (m_tdata[31:0] !== exp_coord.x || m_tdata[63:32] !== exp_coord.y ||
                        m_tdata[95:64] !== exp_coord.z || m_tuser !== exp_coord.ovf ||
                        m_tlast !== exp_coord.last) begin
                        if (mismatch_cnt < MAX_REPORTS)
                            $display("mismatch: exp x=%h y=%h z=%h ovf=%b last=%b,",
                                     exp_coord.x, exp_coord.y, exp_coord.z, exp_coord.ovf,
                                     exp_coord.last,
                                     " got x=%h y=%h z=%h ovf=%b last=%b",
                                     m_tdata[31:0], m_tdata[63:32],
                                     m_tdata[95:64], m_tuser, m_tlast);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            m_tready <= !((hold_trigger && !hold_done) || hold_cnt != 0) &&
                        (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // identity matrix out of reset
        push_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_vertex(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        push_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        wait_drained();

        // saturation high and low, widest accumulator
        load_config(64'h0, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}},
                    {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_vertex(32'h0, 32'h0, 32'h0, 1'b0);
        wait_drained();
        load_config(64'h0, {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}},
                    {2{32'h8000_0000}}, {2{32'h8000_0000}}, {2{32'h8000_0000}});
        push_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        wait_drained();

        // half-unit scale: ties round toward positive infinity
        load_config(64'h0, {32'h0, 32'h0000_8000}, 64'h0, {32'h0000_8000, 32'h0}, 64'h0,
                    64'h0, {32'h0, 32'hFFFF_8000});
        push_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        push_vertex(32'h0000_0003, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 1'b1);
        push_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFD, 1'b0);
        wait_drained();

        // 2D mode through excess mode bits: z and row 2 ignored
        load_config(64'hFFFF_FFFF_FFFF_FFFF, {ELEM_ONE, ELEM_ONE}, {32'h8000_0000, 32'h7FFF_FFFF},
                    {-ELEM_ONE, 32'h0}, {32'h7FFF_FFFF, 32'h7FFF_FFFF},
                    {2{32'h7FFF_FFFF}}, {2{32'h7FFF_FFFF}});
        push_vertex(32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1);
        push_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        wait_drained();

        // clear bit 0 with other bits set: back to 3D
        write_reg(REG_DIM_MODE, 64'h2);
        push_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
        push_vertex(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b1);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            steady <= 1'b0;
            load_config({$urandom, $urandom}, {rand_elem(), rand_elem()},
                        {rand_elem(), rand_elem()}, {rand_elem(), rand_elem()},
                        {rand_elem(), rand_elem()}, {rand_elem(), rand_elem()},
                        {rand_elem(), rand_elem()});
            if (p == 5)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            if (p == 2) begin
                steady <= 1'b1;
                hold_trigger <= 1'b1;
            end
            if (p == 4) begin
                push_random(PHASE_ITEMS / 2);
                wait_drained();
                push_random(PHASE_ITEMS / 2);
            end else begin
                push_random(PHASE_ITEMS);
            end
        end

        wait_drained();
        if (mismatch_cnt == 0 && expected_coords.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
